[rtl/tint_pkg.sv]
// tint_pkg: shared types, constants and helpers for the table interpolator.
// Used by every module of the block but tint_ram; depends on nothing.
package tint_pkg;

	localparam int MAX_POINTS_DEF = 16;
	localparam int DATA_W         = 32;
	localparam int IDX_W          = 4;
	localparam int PC_W           = 5;
	localparam int CFG_DATA_W     = 5;
	localparam int S_TDATA_W      = 104;
	localparam int S_TUSER_W      = 2;
	localparam int M_TDATA_W      = 32;
	localparam int M_TUSER_W      = 2;
	localparam int QDEPTH         = 2;

	localparam logic [63:0] W_ONE   = 64'h0000_0001_0000_0000;
	localparam logic [63:0] W_CAP   = 64'h2000_0000_0000_0000;
	localparam logic [63:0] Q31_ONE = 64'h0000_0000_8000_0000;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_ORDER = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REG_METHOD      = 1'b0,
		REG_POINT_COUNT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic              is_query;
		logic              ld_ok;
		logic              first;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
	} item_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] d;
	} md_req_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_CHK,
		MD_DIV
	} md_state_t;

	typedef enum logic [4:0] {
		BK_IDLE,
		BK_LOAD,
		BK_QRY,
		BK_RX0,
		BK_RXN,
		BK_LCLAMP,
		BK_LSCAN,
		BK_LRD0,
		BK_LF,
		BK_LM,
		BK_GI,
		BK_GXI,
		BK_GJA,
		BK_GJB,
		BK_GJW,
		BK_GC,
		BK_GCW,
		BK_DONE
	} bk_state_t;

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [63:0] cap61(input logic [63:0] v);
		return (v > W_CAP) ? W_CAP : v;
	endfunction

	// magnitude of a 33-bit signed difference
	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

endpackage

[rtl/tint_ram.sv]
// tint_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module tint_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/tint_muldiv.sv]
// tint_muldiv: floor(a * b / d), 128-bit product, saturates to all ones.
// Four 32x32 partial products, then one quotient bit per cycle; a divisor of
// 2^31 or 2^32 is a plain shift of the product. Uses tint_pkg.
module tint_muldiv (
	input  logic               clk,
	input  logic               arst_n,
	input  tint_pkg::md_req_t  req,
	output logic               done,
	output logic [63:0]        quo
);

	tint_pkg::md_state_t state_q, state_d;

	logic [63:0]  a_q, b_q, d_q, rem_q, lo_q, quo_q;
	logic [127:0] prod_q;
	logic [5:0]   cnt_q;
	logic         done_q;

	logic [31:0]  a_part, b_part;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [64:0]  r2;
	logic         qbit;
	logic         ovf;
	logic         pow2;

	assign a_part = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_part = cnt_q[0] ? b_q[63:32] : b_q[31:0];
	assign pp     = a_part * b_part;
	always_comb begin
		unique case ({cnt_q[1], cnt_q[0]})
			2'b00:   pp_sh = {64'd0, pp};
			2'b11:   pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end

	assign r2   = {rem_q, lo_q[63]};
	assign qbit = (r2 >= {1'b0, d_q});
	assign ovf  = (d_q == 64'd0) || (prod_q[127:64] >= d_q);
	// 2^31 and 2^32 divisors: the quotient is a slice of the product
	assign pow2 = (d_q == tint_pkg::W_ONE) || (d_q == tint_pkg::Q31_ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tint_pkg::MD_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == tint_pkg::MD_CHK) && (ovf || pow2)) ||
				((state_q == tint_pkg::MD_DIV) && (cnt_q == 6'd63));
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tint_pkg::MD_IDLE: if (req.start) state_d = tint_pkg::MD_MUL;
			tint_pkg::MD_MUL:  if (cnt_q[1:0] == 2'd3) state_d = tint_pkg::MD_CHK;
			tint_pkg::MD_CHK:  state_d = (ovf || pow2) ? tint_pkg::MD_IDLE : tint_pkg::MD_DIV;
			tint_pkg::MD_DIV:  if (cnt_q == 6'd63) state_d = tint_pkg::MD_IDLE;
			default:           state_d = tint_pkg::MD_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tint_pkg::MD_IDLE: begin
				a_q    <= req.a;
				b_q    <= req.b;
				d_q    <= req.d;
				prod_q <= '0;
				cnt_q  <= '0;
			end
			tint_pkg::MD_MUL: begin
				prod_q <= prod_q + pp_sh;
				cnt_q  <= cnt_q + 6'd1;
			end
			tint_pkg::MD_CHK: begin
				rem_q <= prod_q[127:64];
				lo_q  <= prod_q[63:0];
				cnt_q <= '0;
				if (ovf) quo_q <= '1;
				else if (d_q == tint_pkg::W_ONE) quo_q <= prod_q[95:32];
				else if (d_q == tint_pkg::Q31_ONE) quo_q <= prod_q[94:31];
			end
			tint_pkg::MD_DIV: begin
				rem_q <= qbit ? 64'(r2 - {1'b0, d_q}) : r2[63:0];
				lo_q  <= {lo_q[62:0], 1'b0};
				quo_q <= {quo_q[62:0], qbit};
				cnt_q <= cnt_q + 6'd1;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[rtl/tint_front.sv]
// tint_front: accepts input items, sorts them into loads and queries and
// holds them in a two-entry queue for the back end. Uses tint_pkg.
module tint_front #(
	parameter int MAX_POINTS = tint_pkg::MAX_POINTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tint_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [tint_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                             q_valid,
	output tint_pkg::item_t                  q_item,
	input  logic                             q_pop
);

	tint_pkg::item_t  mem_q [tint_pkg::QDEPTH];
	tint_pkg::item_t  itm;
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;
	logic             push;

	always_comb begin
		itm.is_query = s_tuser[0];
		itm.first    = s_tuser[1];
		itm.idx      = s_tdata[3:0];
		itm.ld_ok    = (32'(s_tdata[3:0]) < MAX_POINTS);
		itm.x        = s_tuser[0] ? s_tdata[99:68] : s_tdata[35:4];
		itm.y        = s_tdata[67:36];
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= itm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

[rtl/tint_back.sv]
// tint_back: sequencer that writes the point tables, checks queries and runs
// linear or Lagrange evaluation on one shared mul/div unit.
// Uses tint_pkg, tint_ram, tint_muldiv.
module tint_back #(
	parameter int MAX_POINTS = tint_pkg::MAX_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          method,
	input  logic [tint_pkg::PC_W-1:0]     point_count,
	input  logic                          q_valid,
	input  tint_pkg::item_t               q_item,
	output logic                          q_pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tint_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [tint_pkg::M_TUSER_W-1:0] m_tuser
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	tint_pkg::bk_state_t state_q, state_d;
	tint_pkg::item_t     itm_q;
	tint_pkg::md_req_t   md_req;
	tint_pkg::status_t   res_st_q, out_st_q;

	logic          md_done;
	logic [63:0]   md_q;
	logic [IW-1:0] raddr, seg_q, seg_c, i_q, j_q;
	logic [31:0]   rd_x, rd_y;
	logic          we;
	logic [CW-1:0] n_w, nm1, nm2;

	logic signed [31:0] qv, rxs, x0_q, x1_q, y1_q, y0_q, xi_q, yi_q, last_q;
	logic signed [32:0] dx, t_raw, t_c, dy_q, num, den;
	logic signed [63:0] lin, sum_q, sum_a, sum_c;
	logic [63:0]   wm_q, cval, res_val_q;
	logic [31:0]   out_val_q;
	logic          neg_q, sgn_q, out_vld_q;
	logic          rng_err, ord_err, adv, skip, j_last, i_last, out_free;

	tint_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
		.clk(clk), .we(we), .waddr(IW'(itm_q.idx)), .wdata(itm_q.x),
		.raddr(raddr), .rdata(rd_x)
	);
	tint_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
		.clk(clk), .we(we), .waddr(IW'(itm_q.idx)), .wdata(itm_q.y),
		.raddr(raddr), .rdata(rd_y)
	);
	tint_muldiv u_md (
		.clk(clk), .arst_n(arst_n), .req(md_req), .done(md_done), .quo(md_q)
	);

	// points in use, clamped to [2, MAX_POINTS]
	always_comb begin
		if (point_count < 5'd2) n_w = CW'(2);
		else if (32'(point_count) > MAX_POINTS) n_w = CW'(MAX_POINTS);
		else n_w = CW'(point_count);
	end
	assign nm1 = n_w - CW'(1);
	assign nm2 = n_w - CW'(2);

	assign qv      = $signed(itm_q.x);
	assign rxs     = $signed(rd_x);
	assign rng_err = (qv < x0_q) || (qv > rxs);
	assign ord_err = !itm_q.first && (qv < last_q);
	assign seg_c   = (CW'(seg_q) > nm2) ? nm2[IW-1:0] : seg_q;
	assign adv     = (CW'(seg_q) < nm2) && (qv > rxs);

	// linear: rd_x/rd_y hold the left end in BK_LRD0
	assign dx    = {x1_q[31], x1_q} - {rxs[31], rxs};
	assign t_raw = {qv[31], qv} - {rxs[31], rxs};
	assign t_c   = t_raw[32] ? 33'sd0 : ((t_raw > dx) ? dx : t_raw);
	assign lin   = dy_q[32] ? (64'(y0_q) - $signed(md_q)) : (64'(y0_q) + $signed(md_q));

	// Lagrange: rd_x holds x_j in BK_GJB
	assign num    = {qv[31], qv} - {rxs[31], rxs};
	assign den    = {xi_q[31], xi_q} - {rxs[31], rxs};
	assign skip   = (j_q == i_q) || (den == 33'sd0);
	assign j_last = (CW'(j_q) == nm1);
	assign i_last = (CW'(i_q) == nm1);
	assign cval   = tint_pkg::cap61(md_q);
	assign sum_a  = (neg_q != yi_q[31]) ? (sum_q - $signed(cval)) : (sum_q + $signed(cval));
	assign sum_c  = (sum_a > $signed(tint_pkg::W_CAP)) ? $signed(tint_pkg::W_CAP) :
		((sum_a < -$signed(tint_pkg::W_CAP)) ? -$signed(tint_pkg::W_CAP) : sum_a);

	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= tint_pkg::BK_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		raddr        = '0;
		we           = 1'b0;
		q_pop        = 1'b0;
		md_req       = '0;
		unique case (state_q)
			tint_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = q_item.is_query ? tint_pkg::BK_QRY : tint_pkg::BK_LOAD;
				end
			end
			tint_pkg::BK_LOAD: begin
				we      = itm_q.ld_ok;
				state_d = tint_pkg::BK_IDLE;
			end
			tint_pkg::BK_QRY: begin
				state_d = tint_pkg::BK_RX0;
			end
			tint_pkg::BK_RX0: begin
				raddr   = nm1[IW-1:0];
				state_d = tint_pkg::BK_RXN;
			end
			tint_pkg::BK_RXN: begin
				if (rng_err || ord_err) state_d = tint_pkg::BK_DONE;
				else if (method) state_d = tint_pkg::BK_GI;
				else state_d = tint_pkg::BK_LCLAMP;
			end
			tint_pkg::BK_LCLAMP: begin
				raddr   = seg_c + IW'(1);
				state_d = tint_pkg::BK_LSCAN;
			end
			tint_pkg::BK_LSCAN: begin
				raddr = adv ? (seg_q + IW'(2)) : seg_q;
				if (!adv) state_d = tint_pkg::BK_LRD0;
			end
			tint_pkg::BK_LRD0: begin
				if (dx <= 33'sd0) begin
					state_d = tint_pkg::BK_DONE;
				end else begin
					md_req.start = 1'b1;
					md_req.a     = 64'(unsigned'(t_c));
					md_req.b     = tint_pkg::Q31_ONE;
					md_req.d     = 64'(unsigned'(dx));
					state_d      = tint_pkg::BK_LF;
				end
			end
			tint_pkg::BK_LF: begin
				if (md_done) begin
					md_req.start = 1'b1;
					md_req.a     = 64'(tint_pkg::mag33(dy_q));
					md_req.b     = md_q;
					md_req.d     = tint_pkg::Q31_ONE;
					state_d      = tint_pkg::BK_LM;
				end
			end
			tint_pkg::BK_LM: begin
				if (md_done) state_d = tint_pkg::BK_DONE;
			end
			tint_pkg::BK_GI: begin
				raddr   = i_q;
				state_d = tint_pkg::BK_GXI;
			end
			tint_pkg::BK_GXI: begin
				state_d = tint_pkg::BK_GJA;
			end
			tint_pkg::BK_GJA: begin
				raddr   = j_q;
				state_d = tint_pkg::BK_GJB;
			end
			tint_pkg::BK_GJB: begin
				if (skip) begin
					state_d = j_last ? tint_pkg::BK_GC : tint_pkg::BK_GJA;
				end else begin
					md_req.start = 1'b1;
					md_req.a     = wm_q;
					md_req.b     = 64'(tint_pkg::mag33(num));
					md_req.d     = 64'(tint_pkg::mag33(den));
					state_d      = tint_pkg::BK_GJW;
				end
			end
			tint_pkg::BK_GJW: begin
				if (md_done) state_d = j_last ? tint_pkg::BK_GC : tint_pkg::BK_GJA;
			end
			tint_pkg::BK_GC: begin
				md_req.start = 1'b1;
				md_req.a     = 64'(tint_pkg::mag33({yi_q[31], yi_q}));
				md_req.b     = wm_q;
				md_req.d     = tint_pkg::W_ONE;
				state_d      = tint_pkg::BK_GCW;
			end
			tint_pkg::BK_GCW: begin
				if (md_done) state_d = i_last ? tint_pkg::BK_DONE : tint_pkg::BK_GI;
			end
			tint_pkg::BK_DONE: begin
				if (out_free) state_d = tint_pkg::BK_IDLE;
			end
			default: state_d = tint_pkg::BK_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q     <= '0;
			last_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == tint_pkg::BK_QRY && itm_q.first) begin
				seg_q  <= '0;
				last_q <= qv;
			end
			if (state_q == tint_pkg::BK_RXN && !rng_err && !ord_err) last_q <= qv;
			if (state_q == tint_pkg::BK_LCLAMP) seg_q <= seg_c;
			if (state_q == tint_pkg::BK_LSCAN && adv) seg_q <= seg_q + IW'(1);
			if (state_q == tint_pkg::BK_DONE && out_free) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			tint_pkg::BK_IDLE: if (q_valid) itm_q <= q_item;
			tint_pkg::BK_RX0:  x0_q <= rxs;
			tint_pkg::BK_RXN: begin
				res_st_q  <= rng_err ? tint_pkg::ST_RANGE :
					(ord_err ? tint_pkg::ST_ORDER : tint_pkg::ST_OK);
				res_val_q <= '0;
				sum_q     <= '0;
				i_q       <= '0;
			end
			tint_pkg::BK_LSCAN: begin
				if (!adv) begin
					x1_q <= rxs;
					y1_q <= $signed(rd_y);
				end
			end
			tint_pkg::BK_LRD0: begin
				y0_q      <= $signed(rd_y);
				dy_q      <= {y1_q[31], y1_q} - {rd_y[31], rd_y};
				res_val_q <= 64'($signed(rd_y));
			end
			tint_pkg::BK_LM: if (md_done) res_val_q <= 64'(tint_pkg::sat32(lin));
			tint_pkg::BK_GI: begin
				wm_q  <= tint_pkg::W_ONE;
				neg_q <= 1'b0;
				j_q   <= '0;
			end
			tint_pkg::BK_GXI: begin
				xi_q <= rxs;
				yi_q <= $signed(rd_y);
			end
			tint_pkg::BK_GJB: begin
				sgn_q <= num[32] ^ den[32];
				if (skip) j_q <= j_q + IW'(1);
			end
			tint_pkg::BK_GJW: begin
				if (md_done) begin
					wm_q  <= tint_pkg::cap61(md_q);
					neg_q <= neg_q ^ sgn_q;
					j_q   <= j_q + IW'(1);
				end
			end
			tint_pkg::BK_GCW: begin
				if (md_done) begin
					sum_q     <= sum_c;
					i_q       <= i_q + IW'(1);
					res_val_q <= 64'(tint_pkg::sat32(sum_c));
				end
			end
			tint_pkg::BK_DONE: begin
				if (out_free) begin
					out_val_q <= res_val_q[31:0];
					out_st_q  <= res_st_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_val_q;
	assign m_tuser  = out_st_q;

endmodule

[rtl/table_interpolator.sv]
// table_interpolator: top level, piecewise linear / Lagrange table lookup.
// Uses tint_pkg, tint_front, tint_back (which holds tint_ram, tint_muldiv).
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------------
//  s_*      | in        | s_tvalid/s_tready | load point or query item
//  m_*      | out       | m_tvalid/m_tready | interpolated value and status
//  cfg_*    | in        | cfg_we            | method, point_count registers
//
// Queries run on the shared mul/div unit (4 partial products, then one
// quotient bit per cycle; a divisor of 2^31 or 2^32 is a shift instead).
// Reset is asynchronous; the point tables are undefined until loaded.
// A two-entry queue sits between intake and the sequencer, and a result
// register on the output lets the next item start while a result waits.
module table_interpolator #(
	parameter int MAX_POINTS = tint_pkg::MAX_POINTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// point_index[3:0], sample_x[35:4], sample_y[67:36], query_x[99:68], zeros
	input  logic [tint_pkg::S_TDATA_W-1:0]    s_tdata,
	// func[0], first_of_batch[1]
	input  logic [tint_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// value[31:0]
	output logic [tint_pkg::M_TDATA_W-1:0]    m_tdata,
	// status[1:0]
	output logic [tint_pkg::M_TUSER_W-1:0]    m_tuser,
	input  logic                              cfg_we,
	input  logic [0:0]                        cfg_index,
	input  logic [tint_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic                       method_q;
	logic [tint_pkg::PC_W-1:0]  pc_q;
	logic                       q_valid, q_pop;
	tint_pkg::item_t            q_item;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= 1'b0;
			pc_q     <= 5'd2;
		end else if (cfg_we) begin
			unique case (tint_pkg::cfg_reg_t'(cfg_index))
				tint_pkg::REG_METHOD:      method_q <= cfg_data[0];
				tint_pkg::REG_POINT_COUNT: pc_q     <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	tint_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	tint_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.method(method_q), .point_count(pc_q),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

endmodule
